// ===== hw/rtl/cdq_pkg.sv =====
// Shared types and constants for the circular deque: opcodes, status codes,
// field widths and the result info struct. No dependencies.
package cdq_pkg;

   localparam int OPCODE_W      = 2;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int COUNT_FIELD_W = 5;
   localparam int DEPTH_DEFAULT = 16;

   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Per-item result fields that do not come out of the ring memory.
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     pop_ok;
      logic [COUNT_FIELD_W-1:0] item_count;
      logic                     is_empty;
      logic                     is_full;
   } rsp_info_type;

endpackage

// ===== hw/rtl/circular_deque.sv =====
// Circular double-ended queue over a ring memory of DEPTH words.
// Depends on cdq_pkg, cdq_ctrl and cdq_ring_mem.
//
//   channel  dir  tdata fields (low bit up)                          ready
//   req_     in   opcode[1:0] push_value[33:2], zero pad to 40 bits   req_tready
//   rsp_     out  status[1:0] data_out[33:2] item_count[38:34]       rsp_tready
//                 is_empty[39] is_full[40], zero pad to 48 bits
//
// Rate: one item per cycle while rsp_tready stays high; a result appears in the
// cycle after its item is accepted. The limit is the single ring memory port, used
// by one push write or one pop read per item, with read data registered.
// Reset: synchronous, clears head, tail, count and the output valid; ring
// contents stay undefined until written, pops only reach written entries.
// Stalls: a result held on rsp_ blocks req_ only while rsp_tready is low.
module circular_deque
   import cdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode, push_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // status, data_out, item_count, is_empty, is_full
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic                accept;
   logic [OPCODE_W-1:0] opcode;
   logic [VALUE_W-1:0]  push_value;
   logic                mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]   mem_addr;
   logic [VALUE_W-1:0]  mem_wr_data, mem_rd_data;
   logic [VALUE_W-1:0]  data_out;
   rsp_info_type        info, info_ff;
   logic                valid_ff, valid_in;

   // Take a new item whenever the output slot is free or drains this cycle.
   assign req_tready = ~valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign opcode     = req_tdata[OPCODE_W-1:0];
   assign push_value = req_tdata[OPCODE_W+VALUE_W-1:OPCODE_W];

   cdq_ctrl #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .opcode      (opcode),
      .push_value  (push_value),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .info        (info)
   );

   // Read data lands in the memory's own register on the accept edge and
   // holds there until the next pop, so it stays put while the output stalls.
   cdq_ring_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // Output slot: advance on accept, drop when taken without a new item.
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         info_ff <= info;
      end
   end

   // Pushes and refused operations return zero data.
   assign data_out   = info_ff.pop_ok ? mem_rd_data : '0;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, info_ff.is_full, info_ff.is_empty, info_ff.item_count,
                        data_out, info_ff.status};

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_not_full_and_empty: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(info_ff.is_full && info_ff.is_empty))
      else $error("result flags full and empty together");

   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && info_ff.status == ST_FULL) |-> (info_ff.is_full && !info_ff.pop_ok))
      else $error("push refused while deque not full");

   a_refused_empty: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && info_ff.status == ST_EMPTY) |-> (info_ff.is_empty && !info_ff.pop_ok))
      else $error("pop refused while deque not empty");

   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without output backpressure");

endmodule

// ===== hw/rtl/cdq_ring_mem.sv =====
// Ring storage of the circular deque: a write port and a read port on one shared
// address, with registered read data. Depends on cdq_pkg.
module cdq_ring_mem
   import cdq_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  addr,
   input  logic [VALUE_W-1:0] wr_data,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cdq_ctrl.sv =====
// Pointer and count control of the circular deque: decodes the opcode,
// checks full and empty, drives the ring memory port. Depends on cdq_pkg.
module cdq_ctrl
   import cdq_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [OPCODE_W-1:0] opcode,
   input  logic [VALUE_W-1:0]  push_value,
   output logic                mem_wr_en,
   output logic                mem_rd_en,
   output logic [ADDR_W-1:0]   mem_addr,
   output logic [VALUE_W-1:0]  mem_wr_data,
   output rsp_info_type        info
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

   logic [ADDR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [ADDR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W+COUNT_FIELD_W-1:0] count_ext;
   logic              full, empty, wr_op, rd_op;
   logic [STATUS_W-1:0] status;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   assign head_inc = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LAST_ADDR : head_ff - 1'b1;
   assign tail_inc = (tail_ff == LAST_ADDR) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? LAST_ADDR : tail_ff - 1'b1;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      status   = ST_DONE;
      wr_op    = 1'b0;
      rd_op    = 1'b0;
      mem_addr = head_ff;
      unique case (opcode)
         OP_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               wr_op    = 1'b1;
               mem_addr = head_dec;
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               wr_op    = 1'b1;
               mem_addr = tail_ff;
               tail_in  = tail_inc;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               rd_op    = 1'b1;
               mem_addr = head_ff;
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               rd_op    = 1'b1;
               mem_addr = tail_dec;
               tail_in  = tail_dec;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   assign mem_wr_en   = accept & wr_op;
   assign mem_rd_en   = accept & rd_op;
   assign mem_wr_data = push_value;

   // Zero-extend the count and keep its low COUNT_FIELD_W bits; counts above 31 do not fit.
   assign count_ext = {{COUNT_FIELD_W{1'b0}}, count_in};

   always_comb begin
      info.status     = status;
      info.pop_ok     = rd_op;
      info.item_count = count_ext[COUNT_FIELD_W-1:0];
      info.is_empty   = (count_in == '0);
      info.is_full    = (count_in == FULL_CNT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule
